// ----- sv/ppucrp_pkg.sv -----
// Shared types and codes for the video chip CPU register port.
`default_nettype none

package ppucrp_pkg;

  typedef enum logic [1:0] {
    OP_REG_READ    = 2'd0,
    OP_REG_WRITE   = 2'd1,
    OP_OAM_DMA     = 2'd2,
    OP_STATUS_LOAD = 2'd3
  } op_e;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [2:0] MIR_HORZ  = 3'd0;
  localparam logic [2:0] MIR_VERT  = 3'd1;
  localparam logic [2:0] MIR_FOUR  = 3'd2;
  localparam logic [2:0] MIR_LOWER = 3'd3;
  localparam logic [2:0] MIR_UPPER = 3'd4;

  localparam logic [13:0] NT_BASE  = 14'h2000;
  localparam logic [13:0] PAL_BASE = 14'h3F00;

  localparam int unsigned PAL_ENTRIES = 32;
  localparam int unsigned OAM_BYTES   = 256;

  typedef struct packed {
    logic capture;
    logic execute;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/ppu_cpu_register_port.sv -----
// Top level: CPU register port of the video chip (sequencer plus datapath).
// Items: an accepted item executes, then its result registers and result strobe are loaded.
// A new item is accepted only once the previous one has executed and busy is low.
// Reset: architectural state, OAM and palette read as zero; the nametable RAM is then swept to zero
// with busy high. The receiver cannot stall results.
`default_nettype none

module ppu_cpu_register_port #(
  parameter int unsigned NAME_RAM_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [2:0]  reg_index_i,
  input  wire logic [7:0]  write_data_i,
  output logic             result_valid_o,
  output logic [7:0]       read_data_o,
  output logic             pattern_write_valid_o,
  output logic [12:0]      pattern_address_o,
  output logic [7:0]       pattern_data_o
);
  import ppucrp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ppucrp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  ppucrp_dp #(
    .NAME_RAM_BYTES (NAME_RAM_BYTES)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_we_i              (cfg_we_i),
    .cfg_data_i            (cfg_data_i),
    .operation_i           (operation_i),
    .reg_index_i           (reg_index_i),
    .write_data_i          (write_data_i),
    .read_data_o           (read_data_o),
    .pattern_write_valid_o (pattern_write_valid_o),
    .pattern_address_o     (pattern_address_o),
    .pattern_data_o        (pattern_data_o)
  );

endmodule

`default_nettype wire

// ----- sv/ppucrp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ppucrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/ppucrp_ctrl.sv -----
// Sequencer: nametable clear after reset, then accept / execute per item.
`default_nettype none

module ppucrp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire ppucrp_pkg::dp_stat_t stat_i,
  output ppucrp_pkg::dp_cmd_t      cmd_o,
  output logic                     busy_o,
  output logic                     done_o
);
  import ppucrp_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_EXEC);
      unique case (state_q)
        ST_CLEAR: begin
          if (stat_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && start_i;
    cmd_o.execute = (state_q == ST_EXEC);
    cmd_o.clear   = (state_q == ST_CLEAR);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- sv/ppucrp_dp.sv -----
// Register file, address logic, OAM / nametable / palette storage and result registers.
`default_nettype none

module ppucrp_dp #(
  parameter int unsigned NAME_RAM_BYTES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ppucrp_pkg::dp_cmd_t cmd_i,
  output ppucrp_pkg::dp_stat_t     stat_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_data_i,
  input  wire logic [1:0]          operation_i,
  input  wire logic [2:0]          reg_index_i,
  input  wire logic [7:0]          write_data_i,
  output logic      [7:0]          read_data_o,
  output logic                     pattern_write_valid_o,
  output logic      [12:0]         pattern_address_o,
  output logic      [7:0]          pattern_data_o
);
  import ppucrp_pkg::*;

  localparam int unsigned NAW = $clog2(NAME_RAM_BYTES);
  localparam int unsigned OAW = $clog2(OAM_BYTES);
  localparam logic [12:0] NT_DEPTH = 13'(NAME_RAM_BYTES);
  localparam logic [NAW-1:0] CLR_LAST = NAW'(NAME_RAM_BYTES - 1);

  // captured item
  op_e        op_q;
  logic [2:0] reg_q;
  logic [7:0] wd_q;

  // architectural state
  logic [2:0]     mirror_q;
  logic           inc32_q, inc32_d;
  logic [2:0]     flags_q, flags_d;
  logic [OAW-1:0] spr_addr_q, spr_addr_d;
  logic           toggle_q, toggle_d;
  logic [14:0]    temp_q, temp_d;
  logic [15:0]    cur_q, cur_d;
  logic [7:0]     buf_q, buf_d;
  logic [7:0]     pal_q [PAL_ENTRIES];
  logic           spr_vld_q [OAM_BYTES];
  logic [NAW-1:0] clr_cnt_q;

  // result registers
  logic [7:0]  rd_q, rd_d;
  logic        pv_q, pv_d;
  logic [12:0] pa_q, pa_d;
  logic [7:0]  pd_q, pd_d;

  logic        spr_we, nt_we, pal_we;
  logic [7:0]  spr_rdata, nt_rdata, spr_val, vram_val;
  logic [13:0] vaddr;
  logic        in_pal, in_nt;
  logic [4:0]  pal_idx;
  logic [1:0]  quad;
  logic [12:0] nt_raw, nt_red;
  logic [NAW-1:0] nt_idx;
  logic [15:0] step;

  logic           nt_ram_we;
  logic [NAW-1:0] nt_ram_waddr;
  logic [7:0]     nt_ram_wdata;

  assign vaddr  = cur_q[13:0];
  assign in_pal = (vaddr >= PAL_BASE);
  assign in_nt  = !in_pal && (vaddr >= NT_BASE);
  assign step   = inc32_q ? 16'd32 : 16'd1;

  // backdrop entries at 0x10/0x14/0x18/0x1C alias the lower half
  always_comb begin
    pal_idx = vaddr[4:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_comb begin
    unique case (mirror_q)
      MIR_HORZ:  quad = {1'b0, vaddr[11]};
      MIR_VERT:  quad = {1'b0, vaddr[10]};
      MIR_FOUR:  quad = vaddr[11:10];
      MIR_LOWER: quad = 2'b00;
      MIR_UPPER: quad = 2'b01;
      default:   quad = vaddr[11:10];
    endcase
    nt_raw = {1'b0, quad, vaddr[9:0]};
    // raw index is below 4096; if depth is at least 2048, one subtract folds it
    nt_red = (nt_raw >= NT_DEPTH) ? (nt_raw - NT_DEPTH) : nt_raw;
    nt_idx = nt_red[NAW-1:0];
  end

  assign spr_val  = spr_vld_q[spr_addr_q] ? spr_rdata : 8'h00;
  assign vram_val = in_pal ? pal_q[pal_idx] : (in_nt ? nt_rdata : 8'h00);

  always_comb begin
    inc32_d    = inc32_q;
    flags_d    = flags_q;
    spr_addr_d = spr_addr_q;
    toggle_d   = toggle_q;
    temp_d     = temp_q;
    cur_d      = cur_q;
    buf_d      = buf_q;
    rd_d       = 8'h00;
    pv_d       = 1'b0;
    pa_d       = 13'h0000;
    pd_d       = 8'h00;
    spr_we     = 1'b0;
    nt_we      = 1'b0;
    pal_we     = 1'b0;
    if (cmd_i.execute) begin
      unique case (op_q)
        OP_REG_READ: begin
          unique case (reg_q)
            REG_STATUS: begin
              rd_d       = {flags_q, 5'b00000};
              flags_d[2] = 1'b0;
              toggle_d   = 1'b0;
            end
            REG_OAM_DATA: begin
              rd_d = spr_val;
            end
            REG_DATA: begin
              cur_d = cur_q + step;
              buf_d = vram_val;
              rd_d  = in_pal ? vram_val : buf_q;
            end
            default: begin
            end
          endcase
        end
        OP_REG_WRITE: begin
          unique case (reg_q)
            REG_CTRL: begin
              inc32_d        = wd_q[2];
              temp_d[11:10]  = wd_q[1:0];
            end
            REG_OAM_ADDR: begin
              spr_addr_d = wd_q;
            end
            REG_OAM_DATA: begin
              spr_we     = 1'b1;
              spr_addr_d = spr_addr_q + 1'b1;
            end
            REG_SCROLL: begin
              if (!toggle_q) begin
                temp_d[4:0] = wd_q[7:3];
                toggle_d    = 1'b1;
              end else begin
                temp_d[14:12] = wd_q[2:0];
                temp_d[9:5]   = wd_q[7:3];
                toggle_d      = 1'b0;
              end
            end
            REG_ADDR: begin
              if (!toggle_q) begin
                temp_d[14]   = 1'b0;
                temp_d[13:8] = wd_q[5:0];
                toggle_d     = 1'b1;
              end else begin
                temp_d[7:0] = wd_q;
                cur_d       = {1'b0, temp_q[14:8], wd_q};
                toggle_d    = 1'b0;
              end
            end
            REG_DATA: begin
              if (in_pal) begin
                pal_we = 1'b1;
              end else if (in_nt) begin
                nt_we = 1'b1;
              end else begin
                pv_d = 1'b1;
                pa_d = vaddr[12:0];
                pd_d = wd_q;
              end
              cur_d = cur_q + step;
            end
            default: begin
              // mask and status writes have no effect in this port
            end
          endcase
        end
        OP_OAM_DMA: begin
          spr_we     = 1'b1;
          spr_addr_d = spr_addr_q + 1'b1;
        end
        OP_STATUS_LOAD: begin
          flags_d = wd_q[7:5];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(operation_i);
      reg_q <= reg_index_i;
      wd_q  <= write_data_i;
    end
    if (cmd_i.execute) begin
      rd_q <= rd_d;
      pv_q <= pv_d;
      pa_q <= pa_d;
      pd_q <= pd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q   <= MIR_HORZ;
      inc32_q    <= 1'b0;
      flags_q    <= 3'b000;
      spr_addr_q <= '0;
      toggle_q   <= 1'b0;
      temp_q     <= 15'h0000;
      cur_q      <= 16'h0000;
      buf_q      <= 8'h00;
      clr_cnt_q  <= '0;
      for (int i = 0; i < PAL_ENTRIES; i++) begin
        pal_q[i] <= 8'h00;
      end
      for (int i = 0; i < OAM_BYTES; i++) begin
        spr_vld_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        mirror_q <= cfg_data_i;
      end
      inc32_q    <= inc32_d;
      flags_q    <= flags_d;
      spr_addr_q <= spr_addr_d;
      toggle_q   <= toggle_d;
      temp_q     <= temp_d;
      cur_q      <= cur_d;
      buf_q      <= buf_d;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (pal_we) begin
        pal_q[pal_idx] <= wd_q;
      end
      if (spr_we) begin
        spr_vld_q[spr_addr_q] <= 1'b1;
      end
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == CLR_LAST);

  assign nt_ram_we    = cmd_i.clear || nt_we;
  assign nt_ram_waddr = cmd_i.clear ? clr_cnt_q : nt_idx;
  assign nt_ram_wdata = cmd_i.clear ? 8'h00 : wd_q;

  ppucrp_ram #(
    .WIDTH (8),
    .DEPTH (OAM_BYTES)
  ) u_oam_ram (
    .clk_i   (clk_i),
    .we_i    (spr_we),
    .waddr_i (spr_addr_q),
    .wdata_i (wd_q),
    .raddr_i (spr_addr_q),
    .rdata_o (spr_rdata)
  );

  ppucrp_ram #(
    .WIDTH (8),
    .DEPTH (NAME_RAM_BYTES)
  ) u_nt_ram (
    .clk_i   (clk_i),
    .we_i    (nt_ram_we),
    .waddr_i (nt_ram_waddr),
    .wdata_i (nt_ram_wdata),
    .raddr_i (nt_idx),
    .rdata_o (nt_rdata)
  );

  assign read_data_o           = rd_q;
  assign pattern_write_valid_o = pv_q;
  assign pattern_address_o     = pa_q;
  assign pattern_data_o        = pd_q;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the video chip CPU register port: predicted results checked against strobes.
`timescale 1ns / 1ps

module tb_top;
  import ppucrp_pkg::*;

  localparam int unsigned NT_BYTES = 4096;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        pattern_write_valid;
    logic [12:0] pattern_address;
    logic [7:0]  pattern_data;
  } port_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_we_i;
  logic [2:0]  cfg_data_i;
  logic [1:0]  operation_i;
  logic [2:0]  reg_index_i;
  logic [7:0]  write_data_i;
  logic        result_valid_o;
  logic [7:0]  read_data_o;
  logic        pattern_write_valid_o;
  logic [12:0] pattern_address_o;
  logic [7:0]  pattern_data_o;

  // predicted port state
  logic [2:0]  mirror_sel;
  logic [7:0]  ctrl_reg;
  logic [2:0]  flags_reg;
  logic [7:0]  oam_ptr;
  logic [7:0]  oam_mem [OAM_BYTES];
  logic        addr_toggle;
  logic [14:0] vram_t;
  logic [15:0] vram_v;
  logic [2:0]  fine_x;
  logic [7:0]  data_buf;
  logic [7:0]  nt_mem [NT_BYTES];
  logic [7:0]  pal_mem [PAL_ENTRIES];

  port_result_t expected_q[$];
  int unsigned  fail_count;
  int unsigned  burst_left;
  int unsigned  items_sent;

  ppu_cpu_register_port #(
    .NAME_RAM_BYTES(NT_BYTES)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (operation_i),
    .reg_index_i          (reg_index_i),
    .write_data_i         (write_data_i),
    .result_valid_o       (result_valid_o),
    .read_data_o          (read_data_o),
    .pattern_write_valid_o(pattern_write_valid_o),
    .pattern_address_o    (pattern_address_o),
    .pattern_data_o       (pattern_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int unsigned nt_slot(logic [13:0] a);
    logic [1:0] quad;
    quad = a[11:10];
    case (mirror_sel)
      MIR_HORZ:  quad = {1'b0, quad[1]};
      MIR_VERT:  quad = {1'b0, quad[0]};
      MIR_LOWER: quad = 2'd0;
      MIR_UPPER: quad = 2'd1;
      default:   ;
    endcase
    return (int'(quad) * 1024 + int'(a[9:0])) % NT_BYTES;
  endfunction

  // backdrop entries 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C
  function automatic int unsigned pal_slot(logic [13:0] a);
    logic [4:0] p;
    p = a[4:0];
    if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
    return int'(p);
  endfunction

  function automatic void advance_vram_addr();
    vram_v = vram_v + (ctrl_reg[2] ? 16'd32 : 16'd1);
  endfunction

  function automatic port_result_t predict_access(op_e op, logic [2:0] idx, logic [7:0] d);
    port_result_t r;
    logic [13:0]  a;
    logic [7:0]   v;
    r = '0;
    a = vram_v[13:0];
    v = '0;
    case (op)
      OP_REG_READ: begin
        case (idx)
          REG_STATUS: begin
            r.read_data = {flags_reg, 5'b0};
            flags_reg[2] = 1'b0;
            addr_toggle = 1'b0;
          end
          REG_OAM_DATA: r.read_data = oam_mem[oam_ptr];
          REG_DATA: begin
            if (a >= PAL_BASE) v = pal_mem[pal_slot(a)];
            else if (a >= NT_BASE) v = nt_mem[nt_slot(a)];
            advance_vram_addr();
            r.read_data = (a >= PAL_BASE) ? v : data_buf;
            data_buf = v;
          end
          default: ;
        endcase
      end
      OP_REG_WRITE: begin
        case (idx)
          REG_CTRL: begin
            ctrl_reg = d;
            vram_t[11:10] = d[1:0];
          end
          REG_OAM_ADDR: oam_ptr = d;
          REG_OAM_DATA: begin
            oam_mem[oam_ptr] = d;
            oam_ptr++;
          end
          REG_SCROLL: begin
            if (!addr_toggle) begin
              fine_x = d[2:0];
              vram_t[4:0] = d[7:3];
            end else begin
              vram_t[14:12] = d[2:0];
              vram_t[9:5] = d[7:3];
            end
            addr_toggle = ~addr_toggle;
          end
          REG_ADDR: begin
            if (!addr_toggle) begin
              vram_t[14:8] = {1'b0, d[5:0]};
            end else begin
              vram_t[7:0] = d;
              vram_v = {1'b0, vram_t};
            end
            addr_toggle = ~addr_toggle;
          end
          REG_DATA: begin
            if (a < NT_BASE) begin
              r.pattern_write_valid = 1'b1;
              r.pattern_address = a[12:0];
              r.pattern_data = d;
            end else if (a < PAL_BASE) begin
              nt_mem[nt_slot(a)] = d;
            end else begin
              pal_mem[pal_slot(a)] = d;
            end
            advance_vram_addr();
          end
          default: ;  // mask has no visible effect, status is read-only
        endcase
      end
      OP_OAM_DMA: begin
        oam_mem[oam_ptr] = d;
        oam_ptr++;
      end
      default: flags_reg = d[7:5];
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    port_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: read_data %0h", read_data_o);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (read_data_o !== exp_r.read_data) begin
          $error("read_data: expected %0h, got %0h", exp_r.read_data, read_data_o);
          fail_count++;
        end
        if (pattern_write_valid_o !== exp_r.pattern_write_valid) begin
          $error("pattern_write_valid: expected %0h, got %0h",
                 exp_r.pattern_write_valid, pattern_write_valid_o);
          fail_count++;
        end
        if (pattern_address_o !== exp_r.pattern_address) begin
          $error("pattern_address: expected %0h, got %0h",
                 exp_r.pattern_address, pattern_address_o);
          fail_count++;
        end
        if (pattern_data_o !== exp_r.pattern_data) begin
          $error("pattern_data: expected %0h, got %0h", exp_r.pattern_data, pattern_data_o);
          fail_count++;
        end
      end
    end
  end

  // sender runs in bursts; some gaps are zero so long stretches go back to back
  task automatic send_item(op_e op, logic [2:0] idx, logic [7:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i) start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start        <= 1'b1;
    operation_i  <= op;
    reg_index_i  <= idx;
    write_data_i <= d;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(predict_access(op, idx, d));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i) start <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mirroring(logic [2:0] m);
    drain_results();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i) mirror_sel = m;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // status read first so the address pair starts on the high byte
  task automatic set_vram_addr(logic [13:0] a);
    send_item(OP_REG_READ, REG_STATUS, 8'($urandom));
    send_item(OP_REG_WRITE, REG_ADDR, {2'($urandom), a[13:8]});
    send_item(OP_REG_WRITE, REG_ADDR, a[7:0]);
  endtask

  task automatic test_status_and_idle_regs();
    logic [2:0] idle_regs [5];
    idle_regs = '{REG_CTRL, REG_MASK, REG_OAM_ADDR, REG_SCROLL, REG_ADDR};
    send_item(OP_STATUS_LOAD, REG_STATUS, 8'hE0);
    send_item(OP_REG_READ, REG_STATUS, 8'h00);
    send_item(OP_REG_READ, REG_STATUS, 8'hFF);
    send_item(OP_REG_WRITE, REG_STATUS, 8'hFF);
    send_item(OP_REG_WRITE, REG_MASK, 8'hFF);
    foreach (idle_regs[i]) send_item(OP_REG_READ, idle_regs[i], 8'hFF);
    send_item(OP_REG_WRITE, REG_SCROLL, 8'hFF);
    send_item(OP_REG_WRITE, REG_SCROLL, 8'h00);
    send_item(OP_STATUS_LOAD, REG_DATA, 8'h1F);
  endtask

  task automatic test_oam();
    send_item(OP_REG_WRITE, REG_OAM_ADDR, 8'hFF);
    send_item(OP_REG_WRITE, REG_OAM_DATA, 8'hA5);  // pointer wraps to 0
    send_item(OP_OAM_DMA, REG_CTRL, 8'h5A);
    send_item(OP_REG_WRITE, REG_OAM_ADDR, 8'hFF);
    send_item(OP_REG_READ, REG_OAM_DATA, 8'h00);
    send_item(OP_REG_READ, REG_OAM_DATA, 8'h00);
  endtask

  task automatic test_vram_regions();
    set_vram_addr(14'h0000);
    send_item(OP_REG_WRITE, REG_DATA, 8'hFF);
    send_item(OP_REG_WRITE, REG_CTRL, 8'hFF);
    set_vram_addr(14'h1FFF);
    send_item(OP_REG_WRITE, REG_DATA, 8'h00);
    send_item(OP_REG_READ, REG_DATA, 8'h00);
    send_item(OP_REG_WRITE, REG_CTRL, 8'h00);
    set_vram_addr(14'h23FF);
    send_item(OP_REG_WRITE, REG_DATA, 8'h11);
    send_item(OP_REG_WRITE, REG_DATA, 8'h22);
    set_vram_addr(14'h2BFF);
    send_item(OP_REG_READ, REG_DATA, 8'h00);
    send_item(OP_REG_READ, REG_DATA, 8'h00);
    set_vram_addr(14'h3F1C);
    send_item(OP_REG_WRITE, REG_DATA, 8'h3C);
    set_vram_addr(14'h3F0C);
    send_item(OP_REG_READ, REG_DATA, 8'h00);
    set_vram_addr(14'h3FFF);
    send_item(OP_REG_WRITE, REG_DATA, 8'hA5);
    send_item(OP_REG_READ, REG_DATA, 8'h00);
  endtask

  // builds v = 0x7FE0 through scroll/addr interleave, then steps by 32 past 16-bit wrap
  task automatic test_vram_addr_wrap();
    send_item(OP_REG_READ, REG_STATUS, 8'h00);
    send_item(OP_REG_WRITE, REG_ADDR, 8'h3F);
    send_item(OP_REG_WRITE, REG_SCROLL, 8'hFF);
    send_item(OP_REG_WRITE, REG_SCROLL, 8'h00);
    send_item(OP_REG_WRITE, REG_ADDR, 8'hE0);
    send_item(OP_REG_WRITE, REG_CTRL, 8'h04);
    repeat (1030) begin
      if ($urandom_range(0, 1) == 0) send_item(OP_REG_READ, REG_DATA, 8'($urandom));
      else send_item(OP_REG_WRITE, REG_DATA, 8'($urandom));
    end
    send_item(OP_REG_WRITE, REG_CTRL, 8'h00);
  endtask

  task automatic run_random_traffic(int unsigned n_items);
    int unsigned goal;
    int unsigned k;
    logic [13:0] a;
    logic [13:0] alias_a;
    logic [7:0]  d;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // write a run, then read it back, often through a mirror
          case ($urandom_range(0, 3))
            0:       a = 14'($urandom_range(0, 16'h1FFF));
            1, 2:    a = 14'($urandom_range(16'h2000, 16'h3EFF));
            default: a = 14'($urandom_range(16'h3F00, 16'h3FFF));
          endcase
          k = $urandom_range(1, 6);
          set_vram_addr(a);
          repeat (k) send_item(OP_REG_WRITE, REG_DATA, 8'($urandom));
          alias_a = a;
          if (a >= PAL_BASE) begin
            alias_a = a ^ 14'($urandom_range(0, 15) << 4);
          end else if (a >= NT_BASE) begin
            alias_a = a ^ 14'($urandom_range(0, 7) << 10);
            if (alias_a >= PAL_BASE || alias_a < NT_BASE) alias_a = a;
          end
          set_vram_addr(alias_a);
          repeat (k + 1) send_item(OP_REG_READ, REG_DATA, 8'($urandom));
        end
        3: send_item(OP_REG_WRITE, REG_CTRL, 8'($urandom));
        4: begin
          send_item(OP_REG_WRITE, REG_SCROLL, 8'($urandom));
          send_item(OP_REG_WRITE, REG_SCROLL, 8'($urandom));
        end
        5: begin
          d = 8'($urandom);
          k = $urandom_range(1, 6);
          send_item(OP_REG_WRITE, REG_OAM_ADDR, d);
          repeat (k) begin
            if ($urandom_range(0, 1) == 0) send_item(OP_OAM_DMA, 3'($urandom), 8'($urandom));
            else send_item(OP_REG_WRITE, REG_OAM_DATA, 8'($urandom));
          end
          send_item(OP_REG_WRITE, REG_OAM_ADDR, d);
          repeat (k) send_item(OP_REG_READ, REG_OAM_DATA, 8'($urandom));
        end
        6: begin
          send_item(OP_STATUS_LOAD, 3'($urandom), 8'($urandom));
          repeat ($urandom_range(1, 2)) send_item(OP_REG_READ, REG_STATUS, 8'($urandom));
        end
        7, 8: begin
          repeat ($urandom_range(1, 6))
            send_item(op_e'(2'($urandom)), 3'($urandom), 8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0) send_item(OP_REG_READ, REG_DATA, 8'($urandom));
            else send_item(OP_REG_WRITE, REG_DATA, 8'($urandom));
          end
        end
      endcase
    end
  endtask

  initial begin
    start        = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    operation_i  = '0;
    reg_index_i  = '0;
    write_data_i = '0;
    rst_ni       = 1'b0;
    mirror_sel   = MIR_HORZ;
    ctrl_reg     = '0;
    flags_reg    = '0;
    oam_ptr      = '0;
    addr_toggle  = 1'b0;
    vram_t       = '0;
    vram_v       = '0;
    fine_x       = '0;
    data_buf     = '0;
    foreach (oam_mem[i]) oam_mem[i] = '0;
    foreach (nt_mem[i]) nt_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    fail_count   = 0;
    burst_left   = 0;
    items_sent   = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_status_and_idle_regs();
    test_oam();
    test_vram_regions();
    drain_results();
    test_vram_addr_wrap();
    // all eight mirroring codes, undefined ones included
    for (int m = 7; m >= 0; m--) begin
      set_mirroring(3'(m));
      run_random_traffic(60);
    end
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ppucrp_pkg.sv
sv/ppucrp_ram.sv
sv/ppucrp_ctrl.sv
sv/ppucrp_dp.sv
sv/ppu_cpu_register_port.sv
tb/tb_top.sv
